// File: rtl/ptb_pkg.sv
`timescale 1ns / 1ps
package ptb_pkg;
    localparam int MaxLen    = 4096;
    localparam int Alphabet  = 26;
    localparam int NodeDepth = MaxLen + 2;
    localparam int PosW      = 13;
    localparam int NodeW     = 13;
    localparam int LenW      = 14;
    localparam int CntW      = 13;
    localparam int ChW       = 5;
    localparam int ChildD    = NodeDepth * Alphabet;
    localparam int ChildW    = 17;
    localparam int NodeAW    = 13;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_W1_LEN, S_W1_CHK, S_CH_CHK,
        S_W2_LEN, S_W2_CHK, S_LC_CHK, S_LC_CNT, S_OUT_CNT
    } t_state;
endpackage

// File: rtl/ptb_if.sv
`timescale 1ns / 1ps
interface ptb_in_if;
    logic       valid;
    logic       ready;
    logic [4:0] letter;
    modport source (output valid, output letter, input ready);
    modport sink   (input valid, input letter, output ready);
endinterface

interface ptb_out_if;
    logic        valid;
    logic        ready;
    logic [12:0] pal_suffix_count;
    logic        full_res;
    modport source (output valid, output pal_suffix_count, output full_res, input ready);
    modport sink   (input valid, input pal_suffix_count, input full_res, output ready);
endinterface

// File: rtl/ptb_node_mem.sv
`timescale 1ns / 1ps
module ptb_node_mem import ptb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [NodeAW-1:0] i_waddr,
    input  logic [LenW-1:0]   i_wlen,
    input  logic [NodeW-1:0]  i_wlink,
    input  logic [CntW-1:0]   i_wcnt,
    input  logic [NodeAW-1:0] i_raddr,
    output logic [LenW-1:0]   o_rlen,
    output logic [NodeW-1:0]  o_rlink,
    output logic [CntW-1:0]   o_rcnt
);
    logic [LenW+NodeW+CntW-1:0] r_mem [NodeDepth];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= {i_wlen, i_wlink, i_wcnt};
        {o_rlen, o_rlink, o_rcnt} <= r_mem[i_raddr];
    end
endmodule

// File: rtl/ptb_child_mem.sv
`timescale 1ns / 1ps
module ptb_child_mem import ptb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ChildW-1:0] i_waddr,
    input  logic [NodeW-1:0]  i_wdata,
    input  logic [ChildW-1:0] i_raddr,
    output logic [NodeW-1:0]  o_rdata
);
    logic [NodeW-1:0] r_mem [ChildD];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: rtl/ptb_text_mem.sv
`timescale 1ns / 1ps
module ptb_text_mem import ptb_pkg::*; (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [PosW-1:0] i_waddr,
    input  logic [ChW-1:0]  i_wdata,
    input  logic [PosW-1:0] i_raddr,
    output logic [ChW-1:0]  o_rdata
);
    logic [ChW-1:0] r_mem [MaxLen+1];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: rtl/palindromic_tree_builder.sv
`timescale 1ns / 1ps
// channel   dir  payload
// s_in      in   letter[4:0]
// m_out     out  pal_suffix_count[12:0], full_res
// Each letter walks suffix links (S_W1_*) and reads its child (S_CH_CHK); a new
// node adds a second walk and a link lookup (S_W2_*, S_LC_*), one read port per
// memory. Full-store letters get full_res and a zero count. After reset a pass
// zeroes all 106548 child entries and writes the two roots; no letter is taken then.
// Output register holds a result until taken; a letter is taken only when the
// output register is empty or drains in the same cycle.
module palindromic_tree_builder import ptb_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    ptb_in_if.sink    s_in,
    ptb_out_if.source m_out
);
    t_state r_st, n_st;
    logic [ChildW-1:0] r_clr, n_clr;
    logic [PosW-1:0]   r_pos, n_pos;
    logic [NodeW-1:0]  r_last, n_last, r_cnt_n, n_cnt_n;
    logic [NodeW-1:0]  r_v, n_v, r_cur, n_cur, r_now, n_now, r_lnk, n_lnk;
    logic [LenW-1:0]   r_curlen, n_curlen;
    logic [PosW+1:0]   r_idx, n_idx;
    logic [ChW-1:0]    r_c, n_c;
    logic              r_ov, n_ov, r_full, n_full;
    logic [CntW-1:0]   r_oc, n_oc;

    logic              nm_we, cm_we, tm_we;
    logic [NodeAW-1:0] nm_wa, nm_ra;
    logic [LenW-1:0]   nm_wl, nm_rl;
    logic [NodeW-1:0]  nm_wk, nm_rk, cm_wd, cm_rd;
    logic [CntW-1:0]   nm_wc, nm_rc;
    logic [ChildW-1:0] cm_wa, cm_ra;
    logic [PosW-1:0]   tm_wa, tm_ra;
    logic [ChW-1:0]    tm_wd, tm_rd;
    logic [PosW+1:0]   idx;
    logic              ext;
    logic [ChW-1:0]    cin;

    ptb_node_mem u_node (.i_clk, .i_we(nm_we), .i_waddr(nm_wa), .i_wlen(nm_wl),
        .i_wlink(nm_wk), .i_wcnt(nm_wc), .i_raddr(nm_ra), .o_rlen(nm_rl),
        .o_rlink(nm_rk), .o_rcnt(nm_rc));
    ptb_child_mem u_child (.i_clk, .i_we(cm_we), .i_waddr(cm_wa), .i_wdata(cm_wd),
        .i_raddr(cm_ra), .o_rdata(cm_rd));
    ptb_text_mem u_text (.i_clk, .i_we(tm_we), .i_waddr(tm_wa), .i_wdata(tm_wd),
        .i_raddr(tm_ra), .o_rdata(tm_rd));

    function automatic logic [ChildW-1:0] caddr(logic [NodeW-1:0] v, logic [ChW-1:0] c);
        return ChildW'(v) * ChildW'(Alphabet) + ChildW'(c);
    endfunction

    assign cin = (s_in.letter >= ChW'(Alphabet)) ? s_in.letter - ChW'(Alphabet) : s_in.letter;
    // idx = pos - len - 1 with len read from memory
    assign idx = {2'b00, r_pos} - {nm_rl[LenW-1], nm_rl} - (PosW+2)'(1);
    always_comb begin
        if (r_idx == {2'b00, r_pos}) ext = 1'b1;
        else if (r_idx[PosW+1] || r_idx == '0) ext = 1'b0;
        else ext = (tm_rd == r_c);
    end

    assign s_in.ready = (r_st == S_IDLE) && (!r_ov || m_out.ready);
    assign m_out.valid = r_ov;
    assign m_out.pal_suffix_count = r_oc;
    assign m_out.full_res = r_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLR; r_clr <= '0; r_pos <= '0; r_last <= '0; r_cnt_n <= NodeW'(1);
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st; r_clr <= n_clr; r_pos <= n_pos; r_last <= n_last;
            r_cnt_n <= n_cnt_n; r_ov <= n_ov;
        end
        r_v <= n_v; r_cur <= n_cur; r_now <= n_now; r_curlen <= n_curlen; r_c <= n_c;
        r_lnk <= n_lnk; r_idx <= n_idx;
        r_full <= n_full; r_oc <= n_oc;
    end

    always_comb begin
        n_st = r_st; n_clr = r_clr; n_pos = r_pos; n_last = r_last; n_cnt_n = r_cnt_n;
        n_v = r_v; n_cur = r_cur; n_now = r_now; n_curlen = r_curlen; n_c = r_c;
        n_lnk = r_lnk; n_idx = r_idx;
        n_ov = r_ov; n_full = r_full; n_oc = r_oc;
        if (m_out.valid && m_out.ready) n_ov = 1'b0;
        nm_we = 1'b0; nm_wa = '0; nm_wl = '0; nm_wk = '0; nm_wc = '0;
        nm_ra = NodeAW'(r_v);
        cm_we = 1'b0; cm_wa = r_clr; cm_wd = '0; cm_ra = caddr(r_cur, r_c);
        tm_we = 1'b0; tm_wa = r_pos; tm_wd = r_c;
        tm_ra = PosW'(idx);
        unique case (r_st)
            S_CLR: begin
                cm_we = 1'b1;
                nm_we = 1'b1;
                if (r_clr == '0) begin
                    nm_wa = '0; nm_wl = '0; nm_wk = NodeW'(1);
                end else if (r_clr == ChildW'(1)) begin
                    nm_wa = NodeAW'(1); nm_wl = '1; nm_wk = '0;
                end else begin
                    nm_we = 1'b0;
                end
                tm_we = (r_clr == '0); tm_wa = '0; tm_wd = '1;
                n_clr = r_clr + ChildW'(1);
                if (r_clr == ChildW'(ChildD - 1)) n_st = S_IDLE;
            end
            S_IDLE: begin
                nm_ra = NodeAW'(r_last);
                if (s_in.valid && s_in.ready) begin
                    if (r_pos >= PosW'(MaxLen)) begin
                        n_full = 1'b1; n_oc = '0; n_ov = 1'b1;
                    end else begin
                        n_full = 1'b0;
                        n_pos = r_pos + PosW'(1);
                        n_c = cin;
                        tm_we = 1'b1; tm_wa = r_pos + PosW'(1); tm_wd = cin;
                        n_v = r_last; n_st = S_W1_LEN;
                    end
                end
            end
            S_W1_LEN: begin
                n_curlen = nm_rl; n_lnk = nm_rk; n_idx = idx;
                n_st = S_W1_CHK;
            end
            S_W1_CHK: begin
                if (ext) begin
                    n_cur = r_v; cm_ra = caddr(r_v, r_c);
                    n_st = S_CH_CHK;
                end else begin
                    n_v = r_lnk; nm_ra = NodeAW'(r_lnk);
                    n_st = S_W1_LEN;
                end
            end
            S_CH_CHK: begin
                n_now = cm_rd;
                if (cm_rd == '0 && (r_cnt_n + NodeW'(1)) < NodeW'(NodeDepth)) begin
                    n_now = r_cnt_n + NodeW'(1); n_cnt_n = r_cnt_n + NodeW'(1);
                    n_v = r_lnk; nm_ra = NodeAW'(r_lnk);
                    n_st = S_W2_LEN;
                end else begin
                    nm_ra = NodeAW'(cm_rd);
                    n_st = S_OUT_CNT;
                end
            end
            S_W2_LEN: begin
                n_lnk = nm_rk; n_idx = idx;
                n_st = S_W2_CHK;
            end
            S_W2_CHK: begin
                if (ext) begin
                    cm_ra = caddr(r_v, r_c);
                    n_st = S_LC_CHK;
                end else begin
                    n_v = r_lnk; nm_ra = NodeAW'(r_lnk);
                    n_st = S_W2_LEN;
                end
            end
            S_LC_CHK: begin
                // suffix link of the new node
                n_lnk = cm_rd; nm_ra = NodeAW'(cm_rd);
                n_st = S_LC_CNT;
            end
            S_LC_CNT: begin
                nm_we = 1'b1; nm_wa = NodeAW'(r_now); nm_wl = r_curlen + LenW'(2);
                nm_wk = r_lnk; nm_wc = nm_rc + CntW'(1);
                cm_we = 1'b1; cm_wa = caddr(r_cur, r_c); cm_wd = r_now;
                n_last = r_now; n_oc = nm_rc + CntW'(1); n_full = 1'b0; n_ov = 1'b1;
                n_st = S_IDLE;
            end
            S_OUT_CNT: begin
                n_last = r_now; n_oc = nm_rc; n_full = 1'b0; n_ov = 1'b1;
                n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
    end
endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import ptb_pkg::*;

    localparam int WatchdogLimit = 400000;
    localparam int HoldCycles    = 400;
    localparam int TextTarget    = 1800;

    typedef struct {
        logic [12:0] count;
        logic        full;
    } t_pal_res;

    typedef struct {
        logic [4:0] letter;
        bit         typed;
        t_pal_res   res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ptb_in_if  s_in ();
    ptb_out_if m_out ();

    palindromic_tree_builder u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_in    (s_in),
        .m_out   (m_out)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor state
    int unsigned text_mem [0:MaxLen];
    int          node_len [NodeDepth];
    int unsigned node_lnk [NodeDepth];
    int unsigned node_cnt [NodeDepth];
    int unsigned child_of [ChildD];
    int unsigned text_pos;
    int unsigned last_pal;
    int unsigned top_node;

    t_pal_res pal_queue[$];
    int       errors = 0;
    int       idle_cycles = 0;
    bit       hold_req = 1'b0;
    bit       holding = 1'b0;

    function automatic bit can_extend(int unsigned v);
        longint idx;
        idx = longint'(text_pos) - longint'(node_len[v]) - 1;
        if (idx == longint'(text_pos)) return 1'b1;
        if (idx <= 0 || idx > MaxLen) return 1'b0;
        return text_mem[idx] == text_mem[text_pos];
    endfunction

    function automatic int unsigned find_ext(int unsigned v);
        int unsigned guard;
        guard = 0;
        while (!can_extend(v) && guard <= NodeDepth) begin
            v = node_lnk[v % NodeDepth] % NodeDepth;
            guard++;
        end
        return v;
    endfunction

    function automatic t_pal_res append_letter(logic [4:0] raw);
        t_pal_res    r;
        int unsigned c, cur, nxt, lk;
        c = int'(raw) % Alphabet;
        if (text_pos >= MaxLen) begin
            r.count = '0;
            r.full = 1'b1;
            return r;
        end
        text_pos++;
        text_mem[text_pos] = c;
        cur = find_ext(last_pal);
        nxt = child_of[cur * Alphabet + c];
        if (nxt == 0 && top_node + 1 < NodeDepth) begin
            nxt = top_node + 1;
            top_node = nxt;
            node_len[nxt] = node_len[cur] + 2;
            lk = child_of[find_ext(node_lnk[cur] % NodeDepth) * Alphabet + c];
            node_lnk[nxt] = lk;
            node_cnt[nxt] = (node_cnt[lk % NodeDepth] + 1) & 32'h1fff;
            child_of[cur * Alphabet + c] = nxt;
        end
        last_pal = nxt;
        r.count = 13'(node_cnt[nxt % NodeDepth]);
        r.full = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // sender
    int gap_left = 0;

    task automatic send_letter(logic [4:0] l, bit typed, t_pal_res want);
        t_pal_res p;
        if (gap_left == 0) begin
            gap_left = $urandom_range(0, 3) == 0 ? $urandom_range(1, 30) : 0;
            if (gap_left > 0) gap_left = -gap_left;
            else gap_left = $urandom_range(1, 40);
        end
        if (gap_left < 0) begin
            s_in.valid <= 1'b0;
            repeat (-gap_left) @(posedge i_clk);
            gap_left = $urandom_range(1, 40);
        end
        s_in.valid <= 1'b1;
        s_in.letter <= l;
        do @(posedge i_clk); while (!s_in.ready);
        gap_left--;
        p = append_letter(l);
        pal_queue.push_back(typed ? want : p);
    endtask

    task automatic drain_results();
        s_in.valid <= 1'b0;
        while (pal_queue.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_pal_res mk(int cnt, bit full);
        t_pal_res r;
        r.count = 13'(cnt);
        r.full = full;
        return r;
    endfunction

    function automatic t_row row(int l, bit typed = 0, int cnt = 0, bit full = 0);
        t_row r;
        r.letter = 5'(l);
        r.typed = typed;
        r.res = mk(cnt, full);
        return r;
    endfunction

    t_row directed[$];

    initial begin
        logic [4:0] half[$];
        int          k, n, mode, alpha;
        s_in.valid = 1'b0;
        s_in.letter = '0;
        text_mem[0] = 31;
        text_pos = 0;
        last_pal = 0;
        top_node = 1;
        node_len[1] = -1;
        node_lnk[0] = 1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed = '{row(0, 1, 1), row(0, 1, 2), row(0, 1, 3), row(25, 1, 1),
                     row(26, 1, 2), row(31, 1, 1), row(5), row(0), row(30),
                     row(4), row(25), row(31), row(1), row(2), row(1), row(16),
                     row(15), row(16)};
        foreach (directed[i])
            send_letter(directed[i].letter, directed[i].typed, directed[i].res);
        drain_results();

        hold_req = 1'b1;
        while (text_pos < TextTarget) begin
            mode = $urandom_range(0, 9);
            if (mode < 2) begin
                send_letter(5'($urandom_range(0, 31)), 0, mk(0, 0));
            end else if (mode < 6) begin
                alpha = $urandom_range(1, 3);
                n = $urandom_range(1, 20);
                for (k = 0; k < n; k++)
                    send_letter(5'($urandom_range(0, alpha)), 0, mk(0, 0));
            end else begin
                half.delete();
                n = $urandom_range(1, 30);
                alpha = $urandom_range(1, 25);
                for (k = 0; k < n; k++) half.push_back(5'($urandom_range(0, alpha)));
                foreach (half[i]) send_letter(half[i], 0, mk(0, 0));
                if ($urandom_range(0, 1)) send_letter(5'($urandom_range(0, 31)), 0, mk(0, 0));
                for (k = n - 1; k >= 0; k--) send_letter(half[k], 0, mk(0, 0));
            end
        end
        send_letter(5'd0, 0, mk(0, 0));
        send_letter(5'd31, 0, mk(0, 0));
        send_letter(5'd26, 0, mk(0, 0));
        drain_results();
        repeat (30) @(posedge i_clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // receiver
    initial begin
        int phase;
        m_out.ready = 1'b0;
        phase = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !holding) begin
                holding = 1'b1;
                m_out.ready <= 1'b0;
                repeat (HoldCycles) @(posedge i_clk);
            end
            phase = (phase + 1) % 64;
            if (phase < 20) m_out.ready <= 1'b1;
            else if (phase < 40) m_out.ready <= (phase % 3) != 0;
            else m_out.ready <= $urandom_range(0, 2) != 0;
        end
    end

    always @(posedge i_clk) begin
        t_pal_res want;
        if (m_out.valid && m_out.ready) begin
            if (pal_queue.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = pal_queue.pop_front();
                if (m_out.pal_suffix_count !== want.count)
                    report_mismatch("pal_suffix_count", m_out.pal_suffix_count, want.count);
                if (m_out.full_res !== want.full)
                    report_mismatch("full_res", m_out.full_res, want.full);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_in.valid && s_in.ready) || (m_out.valid && m_out.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit) begin
            $display("CHECK FAILED");
            $finish;
        end
    end
endmodule
